// ===== rtl/linear_sensor_binarize_autoexposure_defines.svh =====
// Assertion helpers for the checker file.
`ifndef LINEAR_SENSOR_BINARIZE_AUTOEXPOSURE_DEFINES_SVH
`define LINEAR_SENSOR_BINARIZE_AUTOEXPOSURE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define LSBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define LSBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lsba_pkg.sv =====
`default_nettype none

package lsba_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_EDGE_THR   = 3'd0,
    REG_MID_THR    = 3'd1,
    REG_CENTER_THR = 3'd2,
    REG_MIN_TARGET = 3'd3,
    REG_MAX_TARGET = 3'd4,
    REG_TIME_STEP  = 3'd5,
    REG_AUTO_EN    = 3'd6,
    REG_TIME_SET   = 3'd7
  } reg_idx_t;

  // Exposure decision codes
  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_CONVERGED = 3'd1,
    ST_RAISED    = 3'd2,
    ST_LOWERED   = 3'd3,
    ST_LIMIT     = 3'd4
  } status_t;

  // Live configuration
  typedef struct packed {
    logic [11:0] edge_thr;
    logic [11:0] mid_thr;
    logic [11:0] center_thr;
    logic [11:0] min_target;
    logic [11:0] max_target;
    logic [15:0] time_step;
    logic        auto_enable;
  } cfg_t;

  localparam logic [11:0] EDGE_THR_RST   = 12'd1300;
  localparam logic [11:0] MID_THR_RST    = 12'd2000;
  localparam logic [11:0] CENTER_THR_RST = 12'd2500;
  localparam logic [11:0] MIN_TARGET_RST = 12'd1300;
  localparam logic [11:0] MAX_TARGET_RST = 12'd3500;
  localparam logic [15:0] TIME_STEP_RST  = 16'd200;
  localparam logic [15:0] TIME_RST       = 16'd3500;

  // Exposure limits
  localparam logic [12:0] LIMIT_HIGH = 13'd5000;
  localparam logic [11:0] LIMIT_LOW  = 12'd500;
  localparam logic [11:0] SAMPLE_MAX = 12'd4095;

  // Min/max window and zone boundaries
  localparam logic [6:0] WIN_FIRST   = 7'd3;
  localparam logic [6:0] WIN_END     = 7'd125;
  localparam logic [6:0] ZONE_MID_A  = 7'd30;
  localparam logic [6:0] ZONE_CENTER = 7'd50;
  localparam logic [6:0] ZONE_MID_B  = 7'd85;
  localparam logic [6:0] ZONE_EDGE_B = 7'd100;

endpackage

`default_nettype wire

// ===== rtl/linear_sensor_binarize_autoexposure.sv =====
// Linear sensor pixel binarizer with frame-by-frame auto exposure.
//
// Input channel (in_valid/in_ready) carries one 12-bit pixel request per item,
// with in_frame_start marking pixel 0 of a frame. Each request yields exactly one
// result request on the output channel (out_valid/out_ready): pixel index, binary
// bit against the zone threshold, last-pixel flag, window min/max so far, the
// integration time and the exposure decision made on the last pixel.
// Results are registered: an accepted request shows at the outputs in the next
// cycle. Throughput is one pixel per cycle while the receiver does not stall,
// set by the single result register; the compare, min/max and saturating
// add/subtract all sit between the accepted pixel and that register.
// When the receiver stalls, the result register holds and in_ready drops; in_ready
// stays high while the result register is empty or being drained in that cycle.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); writing
// time_setting also loads the integration time. Write it only while idle.
// Synchronous active-low reset restores register defaults, position 0, empty
// window and an integration time of 3500, and empties the result register.

`default_nettype none

module linear_sensor_binarize_autoexposure #(
  parameter int PIXELS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] in_sample,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_pixel_index,
  output logic             out_pixel_bit,
  output logic             out_frame_last,
  output logic [11:0]      out_frame_min,
  output logic [11:0]      out_frame_max,
  output logic [15:0]      out_exposure_time,
  output logic [2:0]       out_exposure_status,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import lsba_pkg::*;

  localparam int PW = $clog2(PIXELS);
  localparam int CW = (PW > 7) ? PW : 7;
  localparam logic [PW-1:0] LAST_POS = PW'(PIXELS - 1);

  cfg_t          cfg_r;
  logic [PW-1:0] pos_r;
  logic [11:0]   min_r;
  logic [11:0]   max_r;
  logic [15:0]   time_r;

  logic          out_valid_r;
  logic [6:0]    idx_out_r;
  logic          bit_r;
  logic          last_r;
  logic [11:0]   min_out_r;
  logic [11:0]   max_out_r;
  logic [15:0]   time_out_r;
  status_t       status_r;

  logic          in_acc;
  logic [PW-1:0] idx;
  logic [CW-1:0] idx_w;
  logic          is_last;
  logic          is_first;
  logic          in_win;
  logic [11:0]   thr;
  logic [11:0]   base_min;
  logic [11:0]   base_max;
  logic [11:0]   min_nxt;
  logic [11:0]   max_nxt;
  logic [15:0]   time_nxt;
  status_t       status_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Resolve the pixel position
  assign idx      = in_frame_start ? '0 : pos_r;
  assign idx_w    = CW'(idx);
  assign is_last  = (idx == LAST_POS);
  assign is_first = (idx == '0);
  assign in_win   = (idx_w >= CW'(WIN_FIRST)) && (idx_w < CW'(WIN_END));

  // Select the zone threshold
  always_comb begin
    if (idx_w < CW'(ZONE_MID_A)) begin
      thr = cfg_r.edge_thr;
    end else if (idx_w < CW'(ZONE_CENTER)) begin
      thr = cfg_r.mid_thr;
    end else if (idx_w < CW'(ZONE_MID_B)) begin
      thr = cfg_r.center_thr;
    end else if (idx_w < CW'(ZONE_EDGE_B)) begin
      thr = cfg_r.mid_thr;
    end else begin
      thr = cfg_r.edge_thr;
    end
  end

  // Restart the window at pixel 0, then fold in this pixel if it lies in the window
  assign base_min = is_first ? SAMPLE_MAX : min_r;
  assign base_max = is_first ? 12'd0 : max_r;
  assign min_nxt  = (in_win && (in_sample < base_min)) ? in_sample : base_min;
  assign max_nxt  = (in_win && (in_sample > base_max)) ? in_sample : base_max;

  lsba_expo u_expo (
    .cfg       (cfg_r),
    .decide    (is_last && cfg_r.auto_enable),
    .frame_min (min_nxt),
    .frame_max (max_nxt),
    .time_cur  (time_r),
    .time_nxt  (time_nxt),
    .status    (status_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_thr    <= EDGE_THR_RST;
      cfg_r.mid_thr     <= MID_THR_RST;
      cfg_r.center_thr  <= CENTER_THR_RST;
      cfg_r.min_target  <= MIN_TARGET_RST;
      cfg_r.max_target  <= MAX_TARGET_RST;
      cfg_r.time_step   <= TIME_STEP_RST;
      cfg_r.auto_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EDGE_THR:   cfg_r.edge_thr    <= cfg_wdata[11:0];
        REG_MID_THR:    cfg_r.mid_thr     <= cfg_wdata[11:0];
        REG_CENTER_THR: cfg_r.center_thr  <= cfg_wdata[11:0];
        REG_MIN_TARGET: cfg_r.min_target  <= cfg_wdata[11:0];
        REG_MAX_TARGET: cfg_r.max_target  <= cfg_wdata[11:0];
        REG_TIME_STEP:  cfg_r.time_step   <= cfg_wdata;
        REG_AUTO_EN:    cfg_r.auto_enable <= cfg_wdata[0];
        REG_TIME_SET:   ;
        default:        ;
      endcase
    end
  end

  // Frame state; a time_setting write loads the integration time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      min_r  <= SAMPLE_MAX;
      max_r  <= 12'd0;
      time_r <= TIME_RST;
    end else begin
      if (cfg_we && (reg_idx_t'(cfg_index) == REG_TIME_SET)) begin
        time_r <= cfg_wdata;
      end else if (in_acc) begin
        time_r <= time_nxt;
      end
      if (in_acc) begin
        pos_r <= is_last ? '0 : idx + 1'b1;
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

  // Result valid: set on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_out_r  <= idx_w[6:0];
      bit_r      <= (in_sample > thr);
      last_r     <= is_last;
      min_out_r  <= min_nxt;
      max_out_r  <= max_nxt;
      time_out_r <= time_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_index     = idx_out_r;
  assign out_pixel_bit       = bit_r;
  assign out_frame_last      = last_r;
  assign out_frame_min       = min_out_r;
  assign out_frame_max       = max_out_r;
  assign out_exposure_time   = time_out_r;
  assign out_exposure_status = status_r;

endmodule

`default_nettype wire

// ===== rtl/lsba_expo.sv =====
`default_nettype none

module lsba_expo (
  input  wire lsba_pkg::cfg_t    cfg,
  input  wire                    decide,
  input  wire logic [11:0]       frame_min,
  input  wire logic [11:0]       frame_max,
  input  wire logic [15:0]       time_cur,
  output logic [15:0]            time_nxt,
  output lsba_pkg::status_t      status
);
  import lsba_pkg::*;

  logic [16:0] raise_sum;
  logic        out_of_limit;
  logic        converged;

  assign raise_sum    = {1'b0, time_cur} + {1'b0, cfg.time_step};
  assign out_of_limit = ({1'b0, frame_max} > LIMIT_HIGH) || (frame_min < LIMIT_LOW);
  assign converged    = (frame_min <= cfg.min_target) && (frame_max >= cfg.max_target);

  // Pick one decision per frame end, saturating the time at both ends
  always_comb begin
    time_nxt = time_cur;
    status   = ST_NONE;
    if (decide) begin
      if (out_of_limit) begin
        status = ST_LIMIT;
      end else if (converged) begin
        status = ST_CONVERGED;
      end else if (frame_max < cfg.max_target) begin
        time_nxt = raise_sum[16] ? 16'hFFFF : raise_sum[15:0];
        status   = ST_RAISED;
      end else begin
        time_nxt = (time_cur > cfg.time_step) ? (time_cur - cfg.time_step) : 16'd0;
        status   = ST_LOWERED;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsba_checker.sv =====
`default_nettype none

`include "linear_sensor_binarize_autoexposure_defines.svh"

module lsba_checker #(
  parameter int PIXELS = 128
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  out_pixel_index,
  input wire logic        out_pixel_bit,
  input wire logic        out_frame_last,
  input wire logic [11:0] out_frame_min,
  input wire logic [11:0] out_frame_max,
  input wire logic [15:0] out_exposure_time,
  input wire logic [2:0]  out_exposure_status
);
  import lsba_pkg::*;

  localparam logic [6:0] LAST_IDX = 7'((PIXELS - 1) % 128);

  logic [51:0] pay;
  logic        stalled;
  logic        decided;
  logic        last_out;
  logic        idx_ok;
  logic        max_seen;
  logic        min_ok;

  // Gather the result payload and the conditions under test
  assign pay      = {out_pixel_index, out_pixel_bit, out_frame_last, out_frame_min,
                     out_frame_max, out_exposure_time, out_exposure_status};
  assign stalled  = out_valid && !out_ready;
  assign decided  = out_valid && (out_exposure_status != ST_NONE);
  assign last_out = out_valid && out_frame_last;
  assign idx_ok   = (out_pixel_index == LAST_IDX);
  assign max_seen = out_valid && (out_frame_max != 12'd0);
  assign min_ok   = (out_frame_min <= out_frame_max);

  // A stalled result request holds its payload
  `LSBA_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(pay), "stalled result moved")

  // Exposure decisions happen only on the last pixel
  `LSBA_ASSERT_NOW(a_status_last, clk, rst_n, decided, out_frame_last, "decision off last pixel")

  // The last-pixel flag matches the frame's final index
  `LSBA_ASSERT_NOW(a_last_index, clk, rst_n, last_out, idx_ok, "last flag on wrong index")

  // Once the window holds a nonzero sample, min cannot exceed max
  `LSBA_ASSERT_NOW(a_min_max, clk, rst_n, max_seen, min_ok, "window min above max")

  // An empty result register never blocks the input
  `LSBA_ASSERT_NOW(a_ready_empty, clk, rst_n, !out_valid, in_ready, "input blocked while empty")

endmodule

bind linear_sensor_binarize_autoexposure lsba_checker #(.PIXELS(PIXELS)) u_lsba_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsba_pkg::*;

  localparam int PIXELS          = 128;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 4;

  // One result request as seen on the output channel
  typedef struct {
    logic [6:0]  pixel_index;
    logic        pixel_bit;
    logic        frame_last;
    logic [11:0] frame_min;
    logic [11:0] frame_max;
    logic [15:0] exposure_time;
    logic [2:0]  exposure_status;
  } pixel_result_t;

  // Tracks the sensor frame and exposure loop, queues expected pixel results
  class exposure_scoreboard;
    int unsigned   frame_pixels;
    logic [11:0]   edge_thr, mid_thr, center_thr, min_target, max_target;
    logic [15:0]   time_step, itime;
    logic          auto_en;
    int unsigned   position;
    logic [11:0]   win_min, win_max;
    pixel_result_t pixel_q[$];
    int unsigned   errors, checked;
    int unsigned   decisions[5];

    function new(int unsigned pixels);
      frame_pixels = pixels;
      edge_thr     = EDGE_THR_RST;
      mid_thr      = MID_THR_RST;
      center_thr   = CENTER_THR_RST;
      min_target   = MIN_TARGET_RST;
      max_target   = MAX_TARGET_RST;
      time_step    = TIME_STEP_RST;
      auto_en      = 1'b1;
      itime        = TIME_RST;
      position     = 0;
      win_min      = SAMPLE_MAX;
      win_max      = '0;
      errors       = 0;
      checked      = 0;
      foreach (decisions[i]) decisions[i] = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] data);
      case (idx)
        REG_EDGE_THR:   edge_thr   = data[11:0];
        REG_MID_THR:    mid_thr    = data[11:0];
        REG_CENTER_THR: center_thr = data[11:0];
        REG_MIN_TARGET: min_target = data[11:0];
        REG_MAX_TARGET: max_target = data[11:0];
        REG_TIME_STEP:  time_step  = data;
        REG_AUTO_EN:    auto_en    = data[0];
        REG_TIME_SET:   itime      = data;
        default: ;
      endcase
    endfunction

    function logic [11:0] zone_threshold(int unsigned idx);
      if (idx < ZONE_MID_A) return edge_thr;
      if (idx < ZONE_CENTER) return mid_thr;
      if (idx < ZONE_MID_B) return center_thr;
      if (idx < ZONE_EDGE_B) return mid_thr;
      return edge_thr;
    endfunction

    // Advance the frame by one accepted pixel request
    function void note_request(logic [11:0] sample, logic frame_start);
      pixel_result_t r;
      int unsigned   idx;
      logic [16:0]   sum;
      status_t       st;
      idx = frame_start ? 0 : position;
      if (idx >= frame_pixels) idx = 0;
      if (idx == 0) begin
        win_min = SAMPLE_MAX;
        win_max = '0;
      end
      r.pixel_bit = (sample > zone_threshold(idx));
      if (idx >= WIN_FIRST && idx < WIN_END) begin
        if (sample < win_min) win_min = sample;
        if (sample > win_max) win_max = sample;
      end
      r.frame_last = (idx == frame_pixels - 1);
      st = ST_NONE;
      // Decide exposure on the last pixel only
      if (r.frame_last && auto_en) begin
        if (win_max > LIMIT_HIGH || win_min < LIMIT_LOW) begin
          st = ST_LIMIT;
        end else if (win_min <= min_target && win_max >= max_target) begin
          st = ST_CONVERGED;
        end else if (win_max < max_target) begin
          sum   = {1'b0, itime} + {1'b0, time_step};
          itime = sum[16] ? 16'hFFFF : sum[15:0];
          st    = ST_RAISED;
        end else begin
          itime = (itime > time_step) ? itime - time_step : 16'd0;
          st    = ST_LOWERED;
        end
      end
      position          = r.frame_last ? 0 : idx + 1;
      r.pixel_index     = 7'(idx);
      r.frame_min       = win_min;
      r.frame_max       = win_max;
      r.exposure_time   = itime;
      r.exposure_status = st;
      pixel_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Compare one result request against the oldest pending pixel
    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pixel_q.size() == 0) begin
        $display("%0t: result with no pending pixel, expected none, actual index %0d",
                 $time, got.pixel_index);
        errors++;
        return;
      end
      want = pixel_q.pop_front();
      checked++;
      if (want.frame_last) decisions[want.exposure_status]++;
      compare_field("pixel_index", want.pixel_index, got.pixel_index);
      compare_field("pixel_bit", want.pixel_bit, got.pixel_bit);
      compare_field("frame_last", want.frame_last, got.frame_last);
      compare_field("frame_min", want.frame_min, got.frame_min);
      compare_field("frame_max", want.frame_max, got.frame_max);
      compare_field("exposure_time", want.exposure_time, got.exposure_time);
      compare_field("exposure_status", want.exposure_status, got.exposure_status);
    endfunction

    function int unsigned pending();
      return pixel_q.size();
    endfunction

    function bit at_frame_head();
      return position == 0;
    endfunction
  endclass

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [11:0] in_sample      = '0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [6:0]  out_pixel_index;
  logic        out_pixel_bit;
  logic        out_frame_last;
  logic [11:0] out_frame_min;
  logic [11:0] out_frame_max;
  logic [15:0] out_exposure_time;
  logic [2:0]  out_exposure_status;
  logic        cfg_we         = 1'b0;
  reg_idx_t    cfg_index      = REG_EDGE_THR;
  logic [15:0] cfg_wdata      = '0;

  exposure_scoreboard sb;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  bit          hold_req   = 1'b0;
  bit          hold_seen  = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned idle_cycles = 0;

  linear_sensor_binarize_autoexposure #(.PIXELS(PIXELS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .in_frame_start      (in_frame_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_index     (out_pixel_index),
    .out_pixel_bit       (out_pixel_bit),
    .out_frame_last      (out_frame_last),
    .out_frame_min       (out_frame_min),
    .out_frame_max       (out_frame_max),
    .out_exposure_time   (out_exposure_time),
    .out_exposure_status (out_exposure_status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Drive out_ready: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every accepted result request
  always @(posedge clk) begin : result_mon
    pixel_result_t got;
    if (rst_n && out_valid && out_ready && sb != null) begin
      got.pixel_index     = out_pixel_index;
      got.pixel_bit       = out_pixel_bit;
      got.frame_last      = out_frame_last;
      got.frame_min       = out_frame_min;
      got.frame_max       = out_frame_max;
      got.exposure_time   = out_exposure_time;
      got.exposure_status = out_exposure_status;
      sb.check_result(got);
    end
  end

  // Stop the run if no request moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one pixel request, with an optional gap first, and hold until taken
  task automatic send_pixel(logic [11:0] sample, logic frame_start);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= sample;
    in_frame_start <= frame_start;
    do @(posedge clk); while (!in_ready);
    sb.note_request(sample, frame_start);
  endtask

  // Drop valid and wait until every pending pixel has come back
  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register; unused upper bits carry junk
  task automatic configure(logic [11:0] edge_t, logic [11:0] mid_t, logic [11:0] center_t,
                           logic [11:0] min_t, logic [11:0] max_t, logic [15:0] step,
                           logic enable, logic [15:0] time_set);
    write_cfg(REG_EDGE_THR, {4'($urandom), edge_t});
    write_cfg(REG_MID_THR, {4'($urandom), mid_t});
    write_cfg(REG_CENTER_THR, {4'($urandom), center_t});
    write_cfg(REG_MIN_TARGET, {4'($urandom), min_t});
    write_cfg(REG_MAX_TARGET, {4'($urandom), max_t});
    write_cfg(REG_TIME_STEP, step);
    write_cfg(REG_AUTO_EN, {15'($urandom), enable});
    write_cfg(REG_TIME_SET, time_set);
  endtask

  // Partial frame with restarts, which never reaches the last pixel or a decision
  task automatic send_fragment();
    int unsigned len;
    len = $urandom_range(40, 1);
    for (int unsigned i = 0; i < len; i++)
      send_pixel(12'($urandom), (i == 0) ? 1'b1 : ($urandom_range(19) == 0));
  endtask

  // Full frame: window pixels in [lo, hi] but one forced low pixel if force_low, others anywhere
  task automatic send_frame(int unsigned lo, int unsigned hi, bit force_low);
    int unsigned low_pix;
    logic [11:0] s;
    logic        fs;
    low_pix = $urandom_range(WIN_END - 1, WIN_FIRST);
    for (int unsigned p = 0; p < PIXELS; p++) begin
      if (p >= WIN_FIRST && p < WIN_END) s = 12'($urandom_range(hi, lo));
      else s = 12'($urandom);
      if (force_low && p == low_pix) s = 12'($urandom_range(LIMIT_LOW - 1, 0));
      // At a frame head the flag is optional, so wrap is exercised too
      if (p == 0) fs = sb.at_frame_head() ? 1'($urandom) : 1'b1;
      else fs = 1'b0;
      send_pixel(s, fs);
    end
  endtask

  initial begin
    logic [12:0] directed_pixels [18];
    directed_pixels = '{
      {1'b1, 12'd0},    {1'b0, 12'd4095}, {1'b0, 12'd1300}, {1'b0, 12'd1301},
      {1'b0, 12'd0},    {1'b0, 12'd4095}, {1'b0, 12'd499},  {1'b0, 12'd500},
      {1'b0, 12'd2047}, {1'b1, 12'd2048}, {1'b1, 12'd1300}, {1'b1, 12'd1301},
      {1'b1, 12'd4095}, {1'b0, 12'd0},    {1'b0, 12'd4095}, {1'b0, 12'd4095},
      {1'b0, 12'd1},    {1'b0, 12'd4094}
    };
    sb = new(PIXELS);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, threshold ties, mid-frame restarts at reset settings
    foreach (directed_pixels[i])
      send_pixel(directed_pixels[i][11:0], directed_pixels[i][12]);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_idle();
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 62; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 62; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      case (ph)
        // Out of limit, all thresholds at zero
        0: configure(12'd0, 12'd0, 12'd0, 12'($urandom), 12'($urandom), 16'd0,
                     1'b1, 16'd0);
        // Raise into the upper saturation
        1: configure(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                     12'hFFF, 16'hFFFF, 1'b1, 16'hFFFF - 16'($urandom_range(100)));
        // Lower into the zero floor
        2: configure(12'($urandom), 12'($urandom), 12'($urandom), 12'd0,
                     12'($urandom_range(999)), 16'hFFFF, 1'b1,
                     16'($urandom_range(100)));
        // Decisions disabled
        default: configure(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                           12'($urandom), 16'($urandom), 1'b0, 16'($urandom));
      endcase
      if ($urandom_range(1) == 1) send_fragment();
      // Hold the receiver off so the result register fills and blocks input
      if (ph == 2) hold_req = !hold_req;
      case (ph)
        0: send_frame(0, 4095, 1'b1);
        1: send_frame(500, 3000, 1'b0);
        2: send_frame(1000, 4095, 1'b0);
        // Partial frames only under both idle patterns
        default: repeat (3) send_fragment();
      endcase
    end

    drain_and_idle();
    repeat (5) @(posedge clk);
    $display("Checked %0d pixel results over %0d exposure phases with four idle patterns.",
             sb.checked, PHASES);
    $display("Frame ends: %0d no decision, %0d converged, %0d raised, %0d lowered, %0d limit.",
             sb.decisions[ST_NONE], sb.decisions[ST_CONVERGED], sb.decisions[ST_RAISED],
             sb.decisions[ST_LOWERED], sb.decisions[ST_LIMIT]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
